>>> sv/itd_pkg.sv
// shared types, constants and a character helper for the integer to digit text block
package itd_pkg;

   localparam int unsigned VALUE_BITS_W = 64;
   localparam int unsigned RADIX_W      = 6;
   localparam int unsigned DIGIT_W      = 6;
   localparam int unsigned CHAR_W       = 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_TEN   = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0]  CHAR_A     = 8'h61;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2d;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 6'd9;
   localparam logic [CHAR_W-1:0]  LETTER_OFS = 8'd10;

   typedef struct packed {
      logic [VALUE_BITS_W-1:0] value_bits;
      logic                    treat_as_signed;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] text_char;
      logic              last_char;
   } rsp_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic               clear;
      logic               shift;
      logic [RADIX_W-1:0] radix;
   } itd_ctrl_type;

   // neighbor link: quotient bit stream plus digit / existence for the readout shift
   typedef struct packed {
      logic               bit_vld;
      logic               bit_val;
      logic [DIGIT_W-1:0] digit;
      logic               nz;
   } itd_link_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SIGN,
      ST_OUT
   } itd_state_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] d_ext;
      d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      if (d > DIGIT_MAX) begin
         return CHAR_A + d_ext - LETTER_OFS;
      end
      return CHAR_ZERO + d_ext;
   endfunction

endpackage

>>> sv/itd_cell.sv
// one bit-serial divide-by-radix cell, also one stage of the digit readout shift chain
module itd_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  itd_pkg::itd_ctrl_type ctrl,
   input  logic                 nz_seed,
   input  itd_pkg::itd_link_type link_in,
   output itd_pkg::itd_link_type link_out
);

   logic [itd_pkg::DIGIT_W-1:0] rem_ff, rem_in;
   logic                        nz_ff, nz_in;
   logic                        vld_ff, vld_in;
   logic                        q_ff, q_in;

   logic [itd_pkg::DIGIT_W:0]   trial;
   logic [itd_pkg::DIGIT_W:0]   radix_ext;
   logic [itd_pkg::DIGIT_W:0]   diff;
   logic                        ge;

   assign trial     = {rem_ff, link_in.bit_val};
   assign radix_ext = {1'b0, ctrl.radix};
   assign ge        = (trial >= radix_ext);
   assign diff      = trial - radix_ext;

   always_comb begin
      rem_in = rem_ff;
      nz_in  = nz_ff;
      vld_in = 1'b0;
      q_in   = q_ff;
      priority if (ctrl.clear) begin
         rem_in = '0;
         nz_in  = nz_seed;
      end else if (ctrl.shift) begin
         rem_in = link_in.digit;
         nz_in  = link_in.nz;
      end else if (link_in.bit_vld) begin
         // restoring step: remainder stays below radix, so diff fits the digit width
         rem_in = ge ? diff[itd_pkg::DIGIT_W-1:0] : trial[itd_pkg::DIGIT_W-1:0];
         q_in   = ge;
         vld_in = 1'b1;
         nz_in  = nz_ff | link_in.bit_val;
      end else begin
         // between passes the cell just holds
         rem_in = rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nz_ff  <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         nz_ff  <= nz_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign link_out.bit_vld = vld_ff;
   assign link_out.bit_val = q_ff;
   assign link_out.digit   = rem_ff;
   assign link_out.nz      = nz_ff;

endmodule

>>> sv/integer_to_digit_text_top.sv
// integer to ascii text converter: divider cell chain, readout sequencer and ports
// a number is converted by a bit-serial division pass, then shifted out of the row; a minus
//   sign, when present, leads the digits, and digit characters then follow one per cycle
// one number is taken at a time: busy stays high through the bit-serial quotient pass
//   through the cell row and the shift readout of the row
// reset: synchronous, radix back to ten, sequencer idle, no strobe; the receiver cannot stall
module integer_to_digit_text_top #(
   parameter int unsigned MAX_DIGITS  = 64,
   parameter int unsigned VALUE_WIDTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  itd_pkg::req_type              req_data,
   // result channel, one character per strobe
   output logic                          rsp_valid,
   output itd_pkg::rsp_type              rsp_data,
   // radix register
   input  logic                          csr_we,
   input  logic [itd_pkg::RADIX_W-1:0]   csr_wdata
);

   // the division pass lasts until the last dividend bit has crossed the whole row
   localparam int unsigned DIV_CYCLES = VALUE_WIDTH + MAX_DIGITS - 1;
   localparam int unsigned CNT_W      = $clog2(DIV_CYCLES);
   localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(DIV_CYCLES - 1);
   localparam logic [CNT_W-1:0] FEED_LIMIT = CNT_W'(VALUE_WIDTH);

   // radix register and its clamped form
   logic [itd_pkg::RADIX_W-1:0] radix_ff, radix_in;
   logic [itd_pkg::RADIX_W-1:0] radix_eff;

   always_comb begin
      radix_in = csr_we ? csr_wdata : radix_ff;
   end

   always_comb begin
      priority if (radix_ff < itd_pkg::RADIX_MIN) begin
         radix_eff = itd_pkg::RADIX_MIN;
      end else if (radix_ff > itd_pkg::RADIX_MAX) begin
         radix_eff = itd_pkg::RADIX_MAX;
      end else begin
         radix_eff = radix_ff;
      end
   end

   // sequencer state
   itd_pkg::itd_state_type state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   minus_ff, minus_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;

   // result output register
   logic             rsp_valid_ff, rsp_valid_in;
   itd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // cell row: links[k] feeds cell k, links[k+1] is what it hands on
   itd_pkg::itd_ctrl_type ctrl;
   itd_pkg::itd_link_type links [0:MAX_DIGITS];
   itd_pkg::itd_link_type feed_link;

   logic                   accept;
   logic [VALUE_WIDTH-1:0] v_masked;
   logic [VALUE_WIDTH-1:0] v_neg;
   logic                   take_neg;
   logic                   top_nz;
   logic                   next_nz;

   assign accept   = start && (state_ff == itd_pkg::ST_IDLE);
   assign v_masked = req_data.value_bits[VALUE_WIDTH-1:0];
   assign v_neg    = ~v_masked + 1'b1;
   // minus only for a negative signed value in base ten
   assign take_neg = req_data.treat_as_signed && (radix_eff == itd_pkg::RADIX_TEN)
                     && v_masked[VALUE_WIDTH-1];

   // top of the row holds the most significant digit still waiting
   assign top_nz  = links[MAX_DIGITS].nz;
   assign next_nz = links[MAX_DIGITS-1].nz;

   // bottom of the row
   assign links[0] = feed_link;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      minus_in     = minus_ff;
      value_in     = value_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ctrl.clear   = 1'b0;
      ctrl.shift   = 1'b0;
      ctrl.radix   = radix_eff;
      // cell zero eats the dividend msb first, nothing flows in from below on readout
      feed_link.bit_vld = 1'b0;
      feed_link.bit_val = value_ff[VALUE_WIDTH-1];
      feed_link.digit   = '0;
      feed_link.nz      = 1'b0;

      unique case (state_ff)
         itd_pkg::ST_IDLE: begin
            if (accept) begin
               ctrl.clear = 1'b1;
               cnt_in     = '0;
               minus_in   = take_neg;
               value_in   = take_neg ? v_neg : v_masked;
               state_in   = itd_pkg::ST_DIV;
            end
         end
         itd_pkg::ST_DIV: begin
            // quotient bits ripple one cell per cycle behind the dividend feed
            if (cnt_ff < FEED_LIMIT) begin
               feed_link.bit_vld = 1'b1;
               value_in          = value_ff << 1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = minus_ff ? itd_pkg::ST_SIGN : itd_pkg::ST_OUT;
            end
         end
         itd_pkg::ST_SIGN: begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.text_char = itd_pkg::CHAR_MINUS;
            rsp_data_in.last_char = 1'b0;
            minus_in              = 1'b0;
            state_in              = itd_pkg::ST_OUT;
         end
         itd_pkg::ST_OUT: begin
            // shift the row up; leading non-digits are dropped, real digits go out
            ctrl.shift = 1'b1;
            if (top_nz) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.text_char = itd_pkg::digit_to_ascii(links[MAX_DIGITS].digit);
               rsp_data_in.last_char = !next_nz;
               if (!next_nz) begin
                  state_in = itd_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = itd_pkg::ST_IDLE;
         end
      endcase
   end

   genvar k;
   generate
      for (k = 0; k < MAX_DIGITS; k++) begin : g_cell
         // cell zero always stands for a digit, even for a zero value
         itd_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .nz_seed  (k == 0),
            .link_in  (links[k]),
            .link_out (links[k+1])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= itd_pkg::RADIX_RESET;
         state_ff     <= itd_pkg::ST_IDLE;
         cnt_ff       <= '0;
         minus_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         radix_ff     <= radix_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         minus_ff     <= minus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != itd_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a request always starts a fresh division pass
   a_start_div: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == itd_pkg::ST_DIV) && (cnt_ff == '0))
      else $error("accepted request did not start a division pass");

   // the last character of a number ends the request
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.last_char) |-> (state_ff == itd_pkg::ST_IDLE))
      else $error("last character seen while the sequencer is still busy");

   // no character without a request in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff != itd_pkg::ST_IDLE))
      else $error("character strobe without a request in flight");

   // minus sign only in base ten
   a_minus_ten: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.text_char == itd_pkg::CHAR_MINUS))
         |-> (radix_eff == itd_pkg::RADIX_TEN))
      else $error("minus sign emitted outside base ten");

endmodule

>>> tb/tb.sv
// self-checking testbench for the integer to digit text converter
`timescale 1ns / 100ps

class digit_text_scoreboard;
   itd_pkg::rsp_type expected_chars[$];
   int mismatches;

   function new();
      mismatches = 0;
   endfunction

   task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   // work out the characters of one accepted request and queue them
   function void convert_number(logic [63:0] value, logic as_signed, logic [5:0] radix_reg);
      logic [63:0] mag;
      logic [5:0] base;
      logic [5:0] digits [64];
      int count;
      itd_pkg::rsp_type c;
      base = radix_reg;
      if (base < itd_pkg::RADIX_MIN) begin
         base = itd_pkg::RADIX_MIN;
      end else if (base > itd_pkg::RADIX_MAX) begin
         base = itd_pkg::RADIX_MAX;
      end
      mag = value;
      if (as_signed && base == itd_pkg::RADIX_TEN && value[63]) begin
         c.text_char = itd_pkg::CHAR_MINUS;
         c.last_char = 1'b0;
         expected_chars.push_back(c);
         mag = ~value + 64'd1;
      end
      count = 0;
      do begin
         digits[count] = 6'(mag % base);
         mag = mag / base;
         count++;
      end while (mag != 0 && count < 64);
      for (int k = count - 1; k >= 0; k--) begin
         if (digits[k] > itd_pkg::DIGIT_MAX) begin
            c.text_char = itd_pkg::CHAR_A + digits[k] - itd_pkg::LETTER_OFS;
         end else begin
            c.text_char = itd_pkg::CHAR_ZERO + digits[k];
         end
         c.last_char = (k == 0);
         expected_chars.push_back(c);
      end
   endfunction

   task check_char(itd_pkg::rsp_type got);
      itd_pkg::rsp_type want;
      if (expected_chars.size() == 0) begin
         report_mismatch($sformatf("unexpected char %h last %b", got.text_char, got.last_char));
         return;
      end
      want = expected_chars.pop_front();
      if (got.text_char !== want.text_char) begin
         report_mismatch($sformatf("text_char %h, want %h", got.text_char, want.text_char));
      end
      if (got.last_char !== want.last_char) begin
         report_mismatch($sformatf("last_char %b, want %b", got.last_char, want.last_char));
      end
   endtask
endclass

module tb;

   // even the slowest items plus sender gaps for ~400 requests stay far below this
   localparam int LIMIT_CYCLES = 500_000;
   // covers the longest conversion, with a leading minus, plus margin
   localparam int SETTLE_CYCLES = 220;
   localparam int MAX_GAP = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   itd_pkg::req_type req_data = '0;
   logic rsp_valid;
   itd_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [itd_pkg::RADIX_W-1:0] csr_wdata = '0;

   // testbench copy of the radix register, starts at the reset value
   logic [itd_pkg::RADIX_W-1:0] radix_now = itd_pkg::RADIX_RESET;
   int sender_idle_pct = 0;
   int cycle_count = 0;
   digit_text_scoreboard text_sb = new();

   always #5 clock = ~clock;

   integer_to_digit_text_top uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // receiver never stalls: every strobed char is checked at the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         text_sb.check_char(rsp_data);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("FAIL integer_to_digit_text_top");
         $finish;
      end
   end

   // one request: optional idle gap, then hold start until the block takes it
   task automatic send_number(logic [63:0] value, logic as_signed);
      int gap;
      gap = 0;
      @(negedge clock);
      while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_data.value_bits = value;
      req_data.treat_as_signed = as_signed;
      // accepted at the first rising edge with busy low
      do @(posedge clock); while (busy !== 1'b0);
      text_sb.convert_number(value, as_signed, radix_now);
   endtask

   // stop sending and wait until every expected char is out and the block is idle
   task automatic wait_until_drained();
      @(negedge clock);
      start = 1'b0;
      while (text_sb.expected_chars.size() != 0 || busy !== 1'b0) begin
         @(negedge clock);
      end
   endtask

   // radix is only written while the block is idle
   task automatic write_radix(logic [itd_pkg::RADIX_W-1:0] r);
      wait_until_drained();
      csr_we = 1'b1;
      csr_wdata = r;
      @(negedge clock);
      csr_we = 1'b0;
      radix_now = r;
   endtask

   // mix of tiny values, corner patterns, random widths and full random words
   function automatic logic [63:0] pick_value();
      logic [63:0] v;
      case ($urandom_range(0, 9))
         0, 1: v = 64'($urandom_range(0, 40));
         2: begin
            case ($urandom_range(0, 3))
               0: v = '0;
               1: v = '1;
               2: v = 64'h8000_0000_0000_0000;
               default: v = 64'h7fff_ffff_ffff_ffff;
            endcase
         end
         3, 4, 5: v = {$urandom, $urandom} >> $urandom_range(0, 63);
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   // base 10 gets its own segment since the minus sign lives only there
   function automatic logic [itd_pkg::RADIX_W-1:0] pick_radix(int seg);
      case (seg)
         0: return itd_pkg::RADIX_TEN;
         1: return itd_pkg::RADIX_W'($urandom_range(2, 36));
         2: return itd_pkg::RADIX_MIN;
         3: return itd_pkg::RADIX_MAX;
         default: return itd_pkg::RADIX_W'($urandom_range(0, 63));
      endcase
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      sender_idle_pct = 18;

      // reset radix is ten: zero, extremes, most negative, sign handling
      send_number('0, 1'b0);
      send_number('0, 1'b1);
      send_number('1, 1'b0);
      send_number('1, 1'b1);
      send_number(64'h8000_0000_0000_0000, 1'b1);
      send_number(64'h8000_0000_0000_0000, 1'b0);
      send_number(64'h7fff_ffff_ffff_ffff, 1'b1);
      send_number(64'd9, 1'b0);
      send_number(64'd10, 1'b1);
      send_number(64'd1234567890, 1'b1);

      // base two: longest text, signed pattern written unsigned
      write_radix(itd_pkg::RADIX_MIN);
      send_number('1, 1'b0);
      send_number(64'h8000_0000_0000_0000, 1'b1);
      send_number(64'd1, 1'b0);

      // base thirty-six: top letter and first two-digit value
      write_radix(itd_pkg::RADIX_MAX);
      send_number('1, 1'b1);
      send_number(64'd35, 1'b0);
      send_number(64'd36, 1'b0);

      write_radix(6'd16);
      send_number(64'hfedc_ba98_7654_3210, 1'b1);

      // radix below two clamps to two
      write_radix(6'd0);
      send_number(64'd5, 1'b0);
      write_radix(6'd1);
      send_number(64'd6, 1'b1);

      // radix above thirty-six clamps to thirty-six
      write_radix(6'd63);
      send_number(64'd35, 1'b0);
      write_radix(6'd37);
      send_number(64'd71, 1'b1);

      write_radix(6'd9);
      send_number(64'd80, 1'b1);

      // random part: three idle settings, five radix segments each
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 52 : 0;
         for (int seg = 0; seg < 5; seg++) begin
            write_radix(pick_radix(seg));
            for (int n = 0; n < 23; n++) begin
               // now and then let the block run completely dry
               if ($urandom_range(0, 49) == 0) begin
                  wait_until_drained();
               end
               send_number(pick_value(), 1'($urandom_range(0, 1)));
            end
         end
      end

      wait_until_drained();
      // catch any stray char after the last expected one
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (text_sb.mismatches == 0 && text_sb.expected_chars.size() == 0) begin
         $display("PASS integer_to_digit_text_top");
      end else begin
         $display("FAIL integer_to_digit_text_top");
      end
      $finish;
   end

endmodule
